### design/assert_macros.svh
// Assertion macros for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AST_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/p256sm_pkg.sv
// Types, constants, field helpers and microcode for the P-256 scalar multiplier.
`timescale 1ns / 1ps

package p256sm_pkg;

   localparam int WORD_W  = 64;
   localparam int FW      = 4;
   localparam int FIELD_W = WORD_W * FW;
   localparam int FUNC_W  = 3;
   localparam int IDX_W   = 2;
   localparam int RA_W    = 4;
   localparam int RF_DEPTH = 16;
   localparam int PC_W    = 6;
   localparam int OP_W    = 4;

   typedef logic [FIELD_W-1:0] fe_type;

   localparam fe_type PRIME =
      256'hffffffff00000001_0000000000000000_00000000ffffffff_ffffffffffffffff;
   localparam fe_type GEN_X =
      256'h6b17d1f2e12c4247_f8bce6e563a440f2_77037d812deb33a0_f4a13945d898c296;
   localparam fe_type GEN_Y =
      256'h4fe342e2fe1a7f9b_8ee7eb4a7c0f9e16_2bce33576b315ece_cbb6406837bf51f5;
   localparam fe_type FE_ZERO = '0;
   localparam fe_type FE_ONE  = fe_type'(1);

   localparam logic [FUNC_W-1:0] FUNC_LOAD_K  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_X  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_Y  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MUL_PT  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_MUL_GEN = 3'd4;

   localparam logic [RA_W-1:0] RA_AX  = 4'd0;
   localparam logic [RA_W-1:0] RA_AY  = 4'd1;
   localparam logic [RA_W-1:0] RA_BX  = 4'd2;
   localparam logic [RA_W-1:0] RA_BY  = 4'd3;
   localparam logic [RA_W-1:0] RA_T   = 4'd4;
   localparam logic [RA_W-1:0] RA_N   = 4'd5;
   localparam logic [RA_W-1:0] RA_D   = 4'd6;
   localparam logic [RA_W-1:0] RA_S   = 4'd7;
   localparam logic [RA_W-1:0] RA_X3  = 4'd8;
   localparam logic [RA_W-1:0] RA_Y3  = 4'd9;
   localparam logic [RA_W-1:0] RA_ONE = 4'd10;

   localparam logic [OP_W-1:0] OP_ADD = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL = 4'd2;
   localparam logic [OP_W-1:0] OP_INV = 4'd3;
   localparam logic [OP_W-1:0] OP_MOV = 4'd4;
   localparam logic [OP_W-1:0] OP_CLR = 4'd5;
   localparam logic [OP_W-1:0] OP_BZ2 = 4'd6;
   localparam logic [OP_W-1:0] OP_BEQ = 4'd7;
   localparam logic [OP_W-1:0] OP_BZ  = 4'd8;
   localparam logic [OP_W-1:0] OP_RET = 4'd9;

   localparam logic [PC_W-1:0] UC_ADD       = 6'd0;
   localparam logic [PC_W-1:0] UC_ADD_RET   = 6'd14;
   localparam logic [PC_W-1:0] UC_ADD_COPYB = 6'd15;
   localparam logic [PC_W-1:0] UC_ADD_EQX   = 6'd18;
   localparam logic [PC_W-1:0] UC_ADD_INF   = 6'd19;
   localparam logic [PC_W-1:0] UC_DBL_A     = 6'd22;
   localparam logic [PC_W-1:0] UC_DBL_B     = 6'd38;
   localparam logic [PC_W-1:0] UC_DBL_B_INF = 6'd54;
   localparam logic [PC_W-1:0] UC_NONE      = 6'd0;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [RA_W-1:0] dst;
      logic [RA_W-1:0] a;
      logic [RA_W-1:0] b;
      logic [PC_W-1:0] tgt;
   } uop_type;

   typedef struct packed {
      logic start;
      logic inv;
   } fu_cmd_type;

   function automatic fe_type f_add(input fe_type a, input fe_type b);
      logic [FIELD_W+1:0] s;
      logic [FIELD_W+1:0] d;
      s = {2'b00, a} + {2'b00, b};
      d = s - {2'b00, PRIME};
      return d[FIELD_W+1] ? s[FIELD_W-1:0] : d[FIELD_W-1:0];
   endfunction

   function automatic fe_type f_sub(input fe_type a, input fe_type b);
      logic [FIELD_W:0] d;
      fe_type w;
      d = {1'b0, a} - {1'b0, b};
      w = a + PRIME - b;
      return d[FIELD_W] ? w : d[FIELD_W-1:0];
   endfunction

   function automatic fe_type f_half(input fe_type x);
      logic [FIELD_W:0] s;
      s = x[0] ? ({1'b0, x} + {1'b0, PRIME}) : {1'b0, x};
      return s[FIELD_W:1];
   endfunction

   function automatic fe_type f_reduce(input fe_type x);
      logic [FIELD_W:0] d;
      d = {1'b0, x} - {1'b0, PRIME};
      return d[FIELD_W] ? x : d[FIELD_W-1:0];
   endfunction

   function automatic uop_type ucode(input logic [PC_W-1:0] pc);
      uop_type u;
      unique case (pc)
         6'd0:  u = '{OP_BZ2, RA_AX, RA_AX, RA_AY, UC_ADD_COPYB};
         6'd1:  u = '{OP_BZ2, RA_AX, RA_BX, RA_BY, UC_ADD_RET};
         6'd2:  u = '{OP_BEQ, RA_AX, RA_AX, RA_BX, UC_ADD_EQX};
         6'd3:  u = '{OP_SUB, RA_N,  RA_BY, RA_AY, UC_NONE};
         6'd4:  u = '{OP_SUB, RA_D,  RA_BX, RA_AX, UC_NONE};
         6'd5:  u = '{OP_INV, RA_D,  RA_D,  RA_D,  UC_NONE};
         6'd6:  u = '{OP_MUL, RA_S,  RA_N,  RA_D,  UC_NONE};
         6'd7:  u = '{OP_MUL, RA_T,  RA_S,  RA_S,  UC_NONE};
         6'd8:  u = '{OP_SUB, RA_T,  RA_T,  RA_AX, UC_NONE};
         6'd9:  u = '{OP_SUB, RA_X3, RA_T,  RA_BX, UC_NONE};
         6'd10: u = '{OP_SUB, RA_T,  RA_AX, RA_X3, UC_NONE};
         6'd11: u = '{OP_MUL, RA_Y3, RA_S,  RA_T,  UC_NONE};
         6'd12: u = '{OP_SUB, RA_AY, RA_Y3, RA_AY, UC_NONE};
         6'd13: u = '{OP_MOV, RA_AX, RA_X3, RA_X3, UC_NONE};
         6'd14: u = '{OP_RET, RA_AX, RA_AX, RA_AX, UC_NONE};
         6'd15: u = '{OP_MOV, RA_AX, RA_BX, RA_BX, UC_NONE};
         6'd16: u = '{OP_MOV, RA_AY, RA_BY, RA_BY, UC_NONE};
         6'd17: u = '{OP_RET, RA_AX, RA_AX, RA_AX, UC_NONE};
         6'd18: u = '{OP_BEQ, RA_AX, RA_AY, RA_BY, UC_DBL_A};
         6'd19: u = '{OP_CLR, RA_AX, RA_AX, RA_AX, UC_NONE};
         6'd20: u = '{OP_CLR, RA_AY, RA_AX, RA_AX, UC_NONE};
         6'd21: u = '{OP_RET, RA_AX, RA_AX, RA_AX, UC_NONE};
         6'd22: u = '{OP_BZ,  RA_AX, RA_AY, RA_AY, UC_ADD_INF};
         6'd23: u = '{OP_MUL, RA_T,  RA_AX, RA_AX, UC_NONE};
         6'd24: u = '{OP_SUB, RA_T,  RA_T,  RA_ONE, UC_NONE};
         6'd25: u = '{OP_ADD, RA_N,  RA_T,  RA_T,  UC_NONE};
         6'd26: u = '{OP_ADD, RA_N,  RA_N,  RA_T,  UC_NONE};
         6'd27: u = '{OP_ADD, RA_D,  RA_AY, RA_AY, UC_NONE};
         6'd28: u = '{OP_INV, RA_D,  RA_D,  RA_D,  UC_NONE};
         6'd29: u = '{OP_MUL, RA_S,  RA_N,  RA_D,  UC_NONE};
         6'd30: u = '{OP_MUL, RA_T,  RA_S,  RA_S,  UC_NONE};
         6'd31: u = '{OP_ADD, RA_X3, RA_AX, RA_AX, UC_NONE};
         6'd32: u = '{OP_SUB, RA_X3, RA_T,  RA_X3, UC_NONE};
         6'd33: u = '{OP_SUB, RA_T,  RA_AX, RA_X3, UC_NONE};
         6'd34: u = '{OP_MUL, RA_Y3, RA_S,  RA_T,  UC_NONE};
         6'd35: u = '{OP_SUB, RA_AY, RA_Y3, RA_AY, UC_NONE};
         6'd36: u = '{OP_MOV, RA_AX, RA_X3, RA_X3, UC_NONE};
         6'd37: u = '{OP_RET, RA_AX, RA_AX, RA_AX, UC_NONE};
         6'd38: u = '{OP_BZ,  RA_AX, RA_BY, RA_BY, UC_DBL_B_INF};
         6'd39: u = '{OP_MUL, RA_T,  RA_BX, RA_BX, UC_NONE};
         6'd40: u = '{OP_SUB, RA_T,  RA_T,  RA_ONE, UC_NONE};
         6'd41: u = '{OP_ADD, RA_N,  RA_T,  RA_T,  UC_NONE};
         6'd42: u = '{OP_ADD, RA_N,  RA_N,  RA_T,  UC_NONE};
         6'd43: u = '{OP_ADD, RA_D,  RA_BY, RA_BY, UC_NONE};
         6'd44: u = '{OP_INV, RA_D,  RA_D,  RA_D,  UC_NONE};
         6'd45: u = '{OP_MUL, RA_S,  RA_N,  RA_D,  UC_NONE};
         6'd46: u = '{OP_MUL, RA_T,  RA_S,  RA_S,  UC_NONE};
         6'd47: u = '{OP_ADD, RA_X3, RA_BX, RA_BX, UC_NONE};
         6'd48: u = '{OP_SUB, RA_X3, RA_T,  RA_X3, UC_NONE};
         6'd49: u = '{OP_SUB, RA_T,  RA_BX, RA_X3, UC_NONE};
         6'd50: u = '{OP_MUL, RA_Y3, RA_S,  RA_T,  UC_NONE};
         6'd51: u = '{OP_SUB, RA_BY, RA_Y3, RA_BY, UC_NONE};
         6'd52: u = '{OP_MOV, RA_BX, RA_X3, RA_X3, UC_NONE};
         6'd53: u = '{OP_RET, RA_AX, RA_AX, RA_AX, UC_NONE};
         6'd54: u = '{OP_CLR, RA_BX, RA_AX, RA_AX, UC_NONE};
         6'd55: u = '{OP_CLR, RA_BY, RA_AX, RA_AX, UC_NONE};
         default: u = '{OP_RET, RA_AX, RA_AX, RA_AX, UC_NONE};
      endcase
      return u;
   endfunction

endpackage

### design/p256sm_req_if.sv
// Request channel interface: load and start words.
`timescale 1ns / 1ps

interface p256sm_req_if import p256sm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [IDX_W-1:0]    word_index;
   logic [WORD_W-1:0]   word_value;

   modport source (output valid, output func, output word_index, output word_value,
                   input ready);
   modport sink   (input valid, input func, input word_index, input word_value,
                   output ready);
endinterface

### design/p256sm_rsp_if.sv
// Response channel interface: result coordinate words.
`timescale 1ns / 1ps

interface p256sm_rsp_if import p256sm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [IDX_W-1:0]    out_index;
   logic [WORD_W-1:0]   out_x_word;
   logic [WORD_W-1:0]   out_y_word;
   logic                at_infinity;
   logic                last;

   modport source (output valid, output out_index, output out_x_word, output out_y_word,
                   output at_infinity, output last, input ready);
   modport sink   (input valid, input out_index, input out_x_word, input out_y_word,
                   input at_infinity, input last, output ready);
endinterface

### design/p256sm_field.sv
// Bit-serial modular multiplier and binary-Euclid inverter for the P-256 field.
`timescale 1ns / 1ps

module p256sm_field import p256sm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  fu_cmd_type cmd,
   input  fe_type     op_a,
   input  fe_type     op_b,
   output logic       done,
   output fe_type     result
);

   localparam int CNT_W = $clog2(FIELD_W);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DBL  = 2'd1;
   localparam logic [1:0] F_ADD  = 2'd2;
   localparam logic [1:0] F_INV  = 2'd3;

   logic [1:0]       st_ff, st_in;
   logic             done_ff, done_in;
   fe_type           u_ff, u_in;
   fe_type           v_ff, v_in;
   fe_type           x1_ff, x1_in;
   fe_type           x2_ff, x2_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [FIELD_W:0] udiff;

   assign udiff = {1'b0, u_ff} - {1'b0, v_ff};

   always_comb begin
      st_in   = st_ff;
      done_in = 1'b0;
      u_in    = u_ff;
      v_in    = v_ff;
      x1_in   = x1_ff;
      x2_in   = x2_ff;
      cnt_in  = cnt_ff;
      unique case (st_ff)
         F_IDLE: begin
            if (cmd.start) begin
               u_in   = op_a;
               x2_in  = FE_ZERO;
               cnt_in = CNT_W'(FIELD_W - 1);
               if (cmd.inv) begin
                  v_in  = PRIME;
                  x1_in = (op_a == FE_ZERO) ? FE_ZERO : FE_ONE;
                  st_in = F_INV;
               end else begin
                  v_in  = op_b;
                  x1_in = FE_ZERO;
                  st_in = F_DBL;
               end
            end
         end
         F_DBL: begin
            x1_in = f_add(x1_ff, x1_ff);
            v_in  = {v_ff[FIELD_W-2:0], 1'b0};
            if (v_ff[FIELD_W-1]) begin
               st_in = F_ADD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  done_in = 1'b1;
                  st_in   = F_IDLE;
               end
            end
         end
         F_ADD: begin
            x1_in  = f_add(x1_ff, u_ff);
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in = 1'b1;
               st_in   = F_IDLE;
            end else begin
               st_in = F_DBL;
            end
         end
         F_INV: begin
            if (u_ff == FE_ONE || u_ff == FE_ZERO) begin
               done_in = 1'b1;
               st_in   = F_IDLE;
            end else if (v_ff == FE_ONE) begin
               x1_in   = x2_ff;
               done_in = 1'b1;
               st_in   = F_IDLE;
            end else if (!u_ff[0]) begin
               u_in  = {1'b0, u_ff[FIELD_W-1:1]};
               x1_in = f_half(x1_ff);
            end else if (!v_ff[0]) begin
               v_in  = {1'b0, v_ff[FIELD_W-1:1]};
               x2_in = f_half(x2_ff);
            end else if (!udiff[FIELD_W]) begin
               u_in  = udiff[FIELD_W-1:0];
               x1_in = f_sub(x1_ff, x2_ff);
            end else begin
               v_in  = v_ff - u_ff;
               x2_in = f_sub(x2_ff, x1_ff);
            end
         end
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= F_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      u_ff   <= u_in;
      v_ff   <= v_in;
      x1_ff  <= x1_in;
      x2_ff  <= x2_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = x1_ff;

endmodule

### design/ecc_p256_scalar_multiply.sv
// Top level of the P-256 scalar multiplier: load stores, point sequencer, register file.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage: each request word carries a function code, a word index and a 64-bit value.
// Function codes 0, 1 and 2 load one word of the scalar, the point x or the point y;
// they produce no response. Code 3 multiplies the loaded point and code 4 the curve
// generator by the loaded scalar; codes 5 to 7 are dropped.
// A multiply is answered by four response words, word index 0 first, each with one
// 64-bit word of x and y, the infinity flag, and last set on the fourth.
// The scalar is scanned right to left, one bit per step, with affine add and double.
// Every field multiplication scans the multiplier bit-serially, a doubling for each bit
// and an addition for each set bit, and every inversion runs one binary-Euclid step
// per cycle. Requests are taken only while the block is idle, one at a time.
// Responses stay stable while ready is low; the block goes back to idle after the
// last word is taken. A synchronous reset returns it to idle with no pending
// response; loaded words are kept only until overwritten.
module ecc_p256_scalar_multiply import p256sm_pkg::*; #(
   parameter int WORDS = 4
) (
   input  logic clock,
   input  logic reset,
   p256sm_req_if.sink   req_chan,
   p256sm_rsp_if.source rsp_chan
);

   localparam int SC_W = WORDS * WORD_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SETUP  = 4'd1;
   localparam logic [3:0] S_SCAN   = 4'd2;
   localparam logic [3:0] S_AFTADD = 4'd3;
   localparam logic [3:0] S_NEXT   = 4'd4;
   localparam logic [3:0] S_FETCH  = 4'd5;
   localparam logic [3:0] S_EXEC   = 4'd6;
   localparam logic [3:0] S_WAIT   = 4'd7;
   localparam logic [3:0] S_RDOUT  = 4'd8;
   localparam logic [3:0] S_CAPT   = 4'd9;
   localparam logic [3:0] S_SEND   = 4'd10;

   localparam logic RET_AFTADD = 1'b0;
   localparam logic RET_NEXT   = 1'b1;
   localparam logic [2:0] SETUP_LAST = 3'd4;

   logic [3:0]        state_ff, state_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic              ret_ff, ret_in;
   logic              gen_ff, gen_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [SC_W-1:0]   sc_ff, sc_in;
   logic [WORD_W-1:0] scalar_ff [FW];
   logic [WORD_W-1:0] px_ff [FW];
   logic [WORD_W-1:0] py_ff [FW];
   fe_type            regfile_ff [RF_DEPTH];
   fe_type            rd_a_ff, rd_b_ff;
   fe_type            out_x_ff, out_y_ff;
   logic              inf_ff;
   logic [IDX_W-1:0]  idx_ff;

   fe_type            scalar_full, px_full, py_full;
   uop_type           uop;
   logic [RA_W-1:0]   rd_addr_a, rd_addr_b;
   logic              wr_en;
   logic [RA_W-1:0]   wr_addr;
   fe_type            wr_data;
   fu_cmd_type        fu_cmd;
   logic              fu_done;
   fe_type            fu_result;
   logic              req_fire, rsp_fire;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign uop      = ucode(pc_ff);

   always_comb begin
      for (int i = 0; i < FW; i++) begin
         scalar_full[i*WORD_W +: WORD_W] = scalar_ff[i];
         px_full[i*WORD_W +: WORD_W]     = px_ff[i];
         py_full[i*WORD_W +: WORD_W]     = py_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         unique case (req_chan.func)
            FUNC_LOAD_K: scalar_ff[req_chan.word_index] <= req_chan.word_value;
            FUNC_LOAD_X: px_ff[req_chan.word_index]     <= req_chan.word_value;
            FUNC_LOAD_Y: py_ff[req_chan.word_index]     <= req_chan.word_value;
            default: ;
         endcase
      end
   end

   always_comb begin
      rd_addr_a = uop.a;
      rd_addr_b = uop.b;
      if (state_ff == S_RDOUT) begin
         rd_addr_a = RA_AX;
         rd_addr_b = RA_AY;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         regfile_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= regfile_ff[rd_addr_a];
      rd_b_ff <= regfile_ff[rd_addr_b];
   end

   p256sm_field u_field (
      .clock  (clock),
      .reset  (reset),
      .cmd    (fu_cmd),
      .op_a   (rd_a_ff),
      .op_b   (rd_b_ff),
      .done   (fu_done),
      .result (fu_result)
   );

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      ret_in   = ret_ff;
      gen_in   = gen_ff;
      cnt_in   = cnt_ff;
      sc_in    = sc_ff;
      wr_en    = 1'b0;
      wr_addr  = uop.dst;
      wr_data  = fu_result;
      fu_cmd   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire &&
                (req_chan.func == FUNC_MUL_PT || req_chan.func == FUNC_MUL_GEN)) begin
               gen_in   = (req_chan.func == FUNC_MUL_GEN);
               sc_in    = SC_W'(scalar_full);
               cnt_in   = '0;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               3'd0: begin
                  wr_addr = RA_BX;
                  wr_data = f_reduce(gen_ff ? GEN_X : px_full);
               end
               3'd1: begin
                  wr_addr = RA_BY;
                  wr_data = f_reduce(gen_ff ? GEN_Y : py_full);
               end
               3'd2: begin
                  wr_addr = RA_AX;
                  wr_data = FE_ZERO;
               end
               3'd3: begin
                  wr_addr = RA_AY;
                  wr_data = FE_ZERO;
               end
               default: begin
                  wr_addr = RA_ONE;
                  wr_data = FE_ONE;
               end
            endcase
            if (cnt_ff == SETUP_LAST) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sc_ff == '0) begin
               state_in = S_RDOUT;
            end else if (sc_ff[0]) begin
               pc_in    = UC_ADD;
               ret_in   = RET_AFTADD;
               state_in = S_FETCH;
            end else begin
               state_in = S_AFTADD;
            end
         end
         S_AFTADD: begin
            if (sc_ff[SC_W-1:1] != '0) begin
               pc_in    = UC_DBL_B;
               ret_in   = RET_NEXT;
               state_in = S_FETCH;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            sc_in    = {1'b0, sc_ff[SC_W-1:1]};
            state_in = S_SCAN;
         end
         S_FETCH: state_in = S_EXEC;
         S_EXEC: begin
            pc_in    = pc_ff + 1'b1;
            state_in = S_FETCH;
            unique case (uop.op) inside
               OP_ADD: begin
                  wr_en   = 1'b1;
                  wr_data = f_add(rd_a_ff, rd_b_ff);
               end
               OP_SUB: begin
                  wr_en   = 1'b1;
                  wr_data = f_sub(rd_a_ff, rd_b_ff);
               end
               OP_MOV: begin
                  wr_en   = 1'b1;
                  wr_data = rd_a_ff;
               end
               OP_CLR: begin
                  wr_en   = 1'b1;
                  wr_data = FE_ZERO;
               end
               OP_MUL, OP_INV: begin
                  fu_cmd.start = 1'b1;
                  fu_cmd.inv   = (uop.op == OP_INV);
                  pc_in        = pc_ff;
                  state_in     = S_WAIT;
               end
               OP_BZ2: begin
                  if (rd_a_ff == FE_ZERO && rd_b_ff == FE_ZERO) begin
                     pc_in = uop.tgt;
                  end
               end
               OP_BEQ: begin
                  if (rd_a_ff == rd_b_ff) begin
                     pc_in = uop.tgt;
                  end
               end
               OP_BZ: begin
                  if (rd_a_ff == FE_ZERO) begin
                     pc_in = uop.tgt;
                  end
               end
               default: begin
                  pc_in    = pc_ff;
                  state_in = (ret_ff == RET_NEXT) ? S_NEXT : S_AFTADD;
               end
            endcase
         end
         S_WAIT: begin
            if (fu_done) begin
               wr_en    = 1'b1;
               pc_in    = pc_ff + 1'b1;
               state_in = S_FETCH;
            end
         end
         S_RDOUT: state_in = S_CAPT;
         S_CAPT:  state_in = S_SEND;
         S_SEND: begin
            if (rsp_fire && idx_ff == IDX_W'(FW - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pc_ff  <= pc_in;
      ret_ff <= ret_in;
      gen_ff <= gen_in;
      cnt_ff <= cnt_in;
      sc_ff  <= sc_in;
      if (state_ff == S_CAPT) begin
         out_x_ff <= rd_a_ff;
         out_y_ff <= rd_b_ff;
         inf_ff   <= (rd_a_ff == FE_ZERO) && (rd_b_ff == FE_ZERO);
         idx_ff   <= '0;
      end else if (rsp_fire) begin
         out_x_ff <= {{WORD_W{1'b0}}, out_x_ff[FIELD_W-1:WORD_W]};
         out_y_ff <= {{WORD_W{1'b0}}, out_y_ff[FIELD_W-1:WORD_W]};
         idx_ff   <= idx_ff + 1'b1;
      end
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = (state_ff == S_SEND);
   assign rsp_chan.out_index   = idx_ff;
   assign rsp_chan.out_x_word  = out_x_ff[WORD_W-1:0];
   assign rsp_chan.out_y_word  = out_y_ff[WORD_W-1:0];
   assign rsp_chan.at_infinity = inf_ff;
   assign rsp_chan.last        = (idx_ff == IDX_W'(FW - 1));

   `AST_SAME(a_done_in_wait, clock, reset, fu_done, state_ff == S_WAIT,
             "Field unit finished outside of a wait step.")
   `AST_NEXT(a_last_to_idle, clock, reset, rsp_fire && rsp_chan.last, state_ff == S_IDLE,
             "Block did not return to idle after the last word.")
   `AST_NEXT(a_start_setup, clock, reset,
             req_fire && (req_chan.func == FUNC_MUL_PT || req_chan.func == FUNC_MUL_GEN),
             state_ff == S_SETUP, "Multiply request did not start setup.")

endmodule
